@@ hdl/rps_pkg.sv @@
// shared constants and fixed-point helpers for the pendulum step block
`timescale 1ns / 1ps
package rps_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned CFG_IDX_W     = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INERTIA = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_INERTIA = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_DAMP     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_DAMP    = 8'd7;

    // turns per radian in Q32 and sine polynomial coefficients in Q30
    localparam logic signed [32:0] INV_TWO_PI = 33'sd683565276;
    localparam logic signed [31:0] S_C1 = 32'sd1686629713;
    localparam logic signed [31:0] S_C3 = 32'sd693598670;
    localparam logic signed [31:0] S_C5 = 32'sd85569306;
    localparam logic signed [31:0] S_C7 = 32'sd5026995;
    localparam logic signed [31:0] S_C9 = 32'sd172273;

    localparam logic signed [66:0] MAX32 = 67'sd2147483647;
    localparam logic signed [66:0] MIN32 = -67'sd2147483648;

    // arithmetic right shift rounding toward zero
    function automatic logic signed [65:0] f_trunc_shr(input logic signed [65:0] x,
                                                        input int sh);
        logic signed [65:0] bias;
        bias = x[65] ? ((66'sd1 <<< sh) - 66'sd1) : 66'sd0;
        return (x + bias) >>> sh;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [66:0] x);
        logic signed [31:0] r;
        if (x > MAX32) begin
            r = 32'sh7fffffff;
        end else if (x < MIN32) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // fixed-point product: scale down toward zero, then saturate
    function automatic logic signed [31:0] f_fmul(input logic signed [65:0] p,
                                                   input int sh);
        return f_sat32(67'(f_trunc_shr(p, sh)));
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [31:0] v,
                                                    input logic [30:0] lim);
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        logic signed [31:0] r;
        hi = $signed({2'b00, lim});
        lo = -hi;
        r  = v;
        if (33'(v) > hi) r = hi[31:0];
        if (33'(v) < lo) r = lo[31:0];
        return r;
    endfunction

endpackage

@@ hdl/rotary_pendulum_sim_step_top.sv @@
// rotary pendulum euler step: sequencer around one shared multiplier and a divider
//
// usage: one word on the input channel (i_in_valid / o_in_ready) is one tick with
// motor and disturbance torque. the block advances both joint angles and velocities
// and returns one word on the output channel (o_out_valid / i_out_ready) with the
// new state and the singular flag. registers are written through the cfg channel
// (i_cfg_valid / o_cfg_ready, always ready) while the block is idle; the user must
// keep to this, the block itself does not enforce it.
// the work is set by the single 33x33 multiplier, which forms 43 products (39 when
// determinant is zero and the divisions are skipped), and by the 1 bit per cycle
// divider that runs once for each of the two accelerations.
// input ready again once the previous result is loaded into the output register.
// reset clears state, registers to their defaults and the output valid.
// a stalled receiver holds the result in the output register; the next word is
// still accepted and computed, and waits for the register to free up.
`timescale 1ns / 1ps
module rotary_pendulum_sim_step_top #(
    parameter int unsigned FRAC_BITS = rps_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [31:0]              i_motor_torque,
    input  logic signed [31:0]              i_disturbance_torque,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_arm_angle,
    output logic signed [31:0]              o_arm_velocity,
    output logic signed [31:0]              o_pendulum_angle,
    output logic signed [31:0]              o_pendulum_velocity,
    output logic                            o_singular,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import rps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    localparam int unsigned SIN_SH = 30 - FRAC_BITS;

    // sequencer steps
    localparam logic [4:0] P_PHASE = 5'd0,  P_USQ  = 5'd1,  P_H7   = 5'd2,  P_H5   = 5'd3;
    localparam logic [4:0] P_H3    = 5'd4,  P_H1   = 5'd5,  P_SCL  = 5'd6,  P_SS   = 5'd7;
    localparam logic [4:0] P_M00   = 5'd8,  P_M01  = 5'd9,  P_HVA  = 5'd10, P_HVB  = 5'd11;
    localparam logic [4:0] P_CSA   = 5'd12, P_C01  = 5'd13, P_C10A = 5'd14, P_C10B = 5'd15;
    localparam logic [4:0] P_R0A   = 5'd16, P_R0B  = 5'd17, P_R1A  = 5'd18, P_R1B  = 5'd19;
    localparam logic [4:0] P_GRAV  = 5'd20, P_DETA = 5'd21, P_DETB = 5'd22, P_N0A  = 5'd23;
    localparam logic [4:0] P_N0B   = 5'd24, P_N1A  = 5'd25, P_N1B  = 5'd26, P_V1   = 5'd27;
    localparam logic [4:0] P_V2    = 5'd28, P_A1   = 5'd29, P_A2   = 5'd30;

    localparam logic [1:0] SIN_S  = 2'd0;
    localparam logic [1:0] SIN_C  = 2'd1;
    localparam logic [1:0] SIN_S2 = 2'd2;

    localparam logic [6:0] DIV_STEPS = 7'd66;

    // configuration
    logic [15:0]        r_ts;
    logic [30:0]        r_vl, r_bi, r_pi;
    logic signed [31:0] r_cg, r_gg, r_ad, r_pd;

    // state and control
    t_state             r_state, n_state;
    logic [4:0]         r_pc, n_pc;
    logic               r_wb, n_wb;
    logic [1:0]         r_sidx, n_sidx;
    logic               r_dsel, n_dsel;
    logic [6:0]         r_dcnt, n_dcnt;
    logic               r_out_valid, n_out_valid;

    // datapath
    logic signed [31:0] r_aa, n_aa, r_pa, n_pa, r_v1, n_v1, r_v2, n_v2;
    logic signed [31:0] r_tau1, n_tau1, r_tau2, n_tau2;
    logic [31:0]        r_sph, n_sph;
    logic [30:0]        r_u2, n_u2;
    logic signed [31:0] r_t, n_t, r_s, n_s, r_c, n_c, r_s2, n_s2, r_x, n_x, r_hv, n_hv;
    logic signed [31:0] r_m00, n_m00, r_m01, n_m01, r_c00, n_c00, r_c01, n_c01;
    logic signed [31:0] r_c10, n_c10, r_acc, n_acc, r_r0, n_r0, r_r1, n_r1;
    logic signed [31:0] r_a0, n_a0, r_a1, n_a1;
    logic signed [65:0] r_big, n_big;
    logic [65:0]        r_dmag, n_dmag, r_dq, n_dq, r_rem, n_rem;
    logic               r_qneg, n_qneg, r_sing, n_sing, r_dneg, n_dneg;
    logic signed [65:0] r_prod;

    logic signed [31:0] r_o_aa, r_o_av, r_o_pa, r_o_pv;
    logic               r_o_sing;

    // combinational helpers
    logic signed [32:0] w_ma, w_mb;
    logic [30:0]        w_u;
    logic signed [31:0] w_fm, w_tmp, w_sinv, w_q32;
    logic signed [65:0] w_t30, w_sc, w_diff, w_det, w_half;
    logic [65:0]        w_trial, w_dabs;
    logic               w_ge, w_load_out;
    logic signed [66:0] w_q67, w_qs;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_arm_angle         = r_o_aa;
    assign o_arm_velocity      = r_o_av;
    assign o_pendulum_angle    = r_o_pa;
    assign o_pendulum_velocity = r_o_pv;
    assign o_singular          = r_o_sing;

    // sine argument folded into the first quadrant
    assign w_u = r_sph[30] ? (31'h40000000 - {1'b0, r_sph[29:0]}) : {1'b0, r_sph[29:0]};

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_pc)
            P_PHASE: begin w_ma = 33'(r_pa);  w_mb = INV_TWO_PI; end
            P_USQ:   begin w_ma = $signed({2'b00, w_u}); w_mb = $signed({2'b00, w_u}); end
            P_H7, P_H5, P_H3, P_H1: begin
                w_ma = $signed({2'b00, r_u2}); w_mb = 33'(r_t);
            end
            P_SCL:   begin w_ma = $signed({2'b00, w_u}); w_mb = 33'(r_t); end
            P_SS:    begin w_ma = 33'(r_s);   w_mb = 33'(r_s); end
            P_M00:   begin w_ma = $signed({2'b00, r_pi}); w_mb = 33'(r_x); end
            P_M01:   begin w_ma = 33'(r_cg);  w_mb = 33'(r_c); end
            P_HVA:   begin w_ma = 33'(r_v2);  w_mb = $signed({2'b00, r_pi}); end
            P_HVB:   begin w_ma = 33'(r_x);   w_mb = 33'(r_s2); end
            P_CSA:   begin w_ma = 33'(r_cg);  w_mb = 33'(r_s); end
            P_C01:   begin w_ma = 33'(r_x);   w_mb = 33'(r_v2); end
            P_C10A:  begin w_ma = 33'(r_v1);  w_mb = $signed({2'b00, r_pi}); end
            P_C10B:  begin w_ma = 33'(r_x);   w_mb = 33'(r_s2); end
            P_R0A:   begin w_ma = 33'(r_c00); w_mb = 33'(r_v1); end
            P_R0B:   begin w_ma = 33'(r_c01); w_mb = 33'(r_v2); end
            P_R1A:   begin w_ma = 33'(r_c10); w_mb = 33'(r_v1); end
            P_R1B:   begin w_ma = 33'(r_pd);  w_mb = 33'(r_v2); end
            P_GRAV:  begin w_ma = 33'(r_gg);  w_mb = 33'(r_s); end
            P_DETA:  begin w_ma = 33'(r_m00); w_mb = $signed({2'b00, r_pi}); end
            P_DETB:  begin w_ma = 33'(r_m01); w_mb = 33'(r_m01); end
            P_N0A:   begin w_ma = $signed({2'b00, r_pi}); w_mb = 33'(r_r0); end
            P_N0B:   begin w_ma = 33'(r_m01); w_mb = 33'(r_r1); end
            P_N1A:   begin w_ma = 33'(r_m00); w_mb = 33'(r_r1); end
            P_N1B:   begin w_ma = 33'(r_m01); w_mb = 33'(r_r0); end
            P_V1:    begin w_ma = 33'(r_a0);  w_mb = $signed({17'd0, r_ts}); end
            P_V2:    begin w_ma = 33'(r_a1);  w_mb = $signed({17'd0, r_ts}); end
            P_A1:    begin w_ma = 33'(r_v1);  w_mb = $signed({17'd0, r_ts}); end
            P_A2:    begin w_ma = 33'(r_v2);  w_mb = $signed({17'd0, r_ts}); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // product post-processing shared by the writeback steps
    assign w_fm   = f_fmul(r_prod, FRAC_BITS);
    assign w_t30  = f_trunc_shr(r_prod, 30);
    assign w_sc   = f_trunc_shr(w_t30, SIN_SH);
    assign w_sinv = r_sph[31] ? -w_sc[31:0] : w_sc[31:0];
    assign w_half = f_trunc_shr(66'(w_fm), 1);
    assign w_diff = r_big - r_prod;
    assign w_det  = f_trunc_shr(w_diff, FRAC_BITS);
    assign w_dabs = w_diff[65] ? 66'(-w_diff) : 66'(w_diff);

    // restoring divider, one quotient bit per cycle
    assign w_trial = {r_rem[64:0], r_dq[65]};
    assign w_ge    = (w_trial >= r_dmag);
    assign w_q67   = $signed({1'b0, r_dq});
    assign w_qs    = r_qneg ? -w_q67 : w_q67;
    assign w_q32   = f_sat32(w_qs);

    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;  n_pc = r_pc;  n_wb = r_wb;  n_sidx = r_sidx;
        n_dsel = r_dsel;  n_dcnt = r_dcnt;
        n_aa = r_aa;  n_pa = r_pa;  n_v1 = r_v1;  n_v2 = r_v2;
        n_tau1 = r_tau1;  n_tau2 = r_tau2;  n_sph = r_sph;  n_u2 = r_u2;  n_t = r_t;
        n_s = r_s;  n_c = r_c;  n_s2 = r_s2;  n_x = r_x;  n_hv = r_hv;
        n_m00 = r_m00;  n_m01 = r_m01;  n_c00 = r_c00;  n_c01 = r_c01;  n_c10 = r_c10;
        n_acc = r_acc;  n_r0 = r_r0;  n_r1 = r_r1;  n_a0 = r_a0;  n_a1 = r_a1;
        n_big = r_big;  n_dmag = r_dmag;  n_dq = r_dq;  n_rem = r_rem;
        n_qneg = r_qneg;  n_sing = r_sing;  n_dneg = r_dneg;
        n_out_valid = r_out_valid;
        w_tmp = '0;

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_tau1  = i_motor_torque;
                    n_tau2  = i_disturbance_torque;
                    n_pc    = P_PHASE;
                    n_wb    = 1'b0;
                    n_sing  = 1'b0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (!r_wb) begin
                    // product lands in r_prod this edge
                    n_wb = 1'b1;
                end else begin
                    n_wb = 1'b0;
                    n_pc = r_pc + 5'd1;
                    case (r_pc)
                        P_PHASE: begin
                            n_sph  = r_prod[FRAC_BITS+31:FRAC_BITS];
                            n_sidx = SIN_S;
                        end
                        P_USQ: begin
                            n_u2 = w_t30[30:0];
                            n_t  = S_C9;
                        end
                        P_H7: n_t = S_C7 - w_t30[31:0];
                        P_H5: n_t = S_C5 - w_t30[31:0];
                        P_H3: n_t = S_C3 - w_t30[31:0];
                        P_H1: n_t = S_C1 - w_t30[31:0];
                        P_SCL: begin
                            case (r_sidx)
                                SIN_S: begin
                                    n_s    = w_sinv;
                                    n_sph  = r_sph + 32'h40000000;
                                    n_sidx = SIN_C;
                                    n_pc   = P_USQ;
                                end
                                SIN_C: begin
                                    // double angle from the original phase
                                    n_c    = w_sinv;
                                    n_sph  = {r_sph[30:0], 1'b0} + 32'h80000000;
                                    n_sidx = SIN_S2;
                                    n_pc   = P_USQ;
                                end
                                default: n_s2 = w_sinv;
                            endcase
                        end
                        P_SS:  n_x = w_fm;
                        P_M00: n_m00 = f_sat32($signed({36'd0, r_bi}) + 67'(w_fm));
                        P_M01: n_m01 = w_fm;
                        P_HVA: n_x = w_fm;
                        P_HVB: n_hv = w_half[31:0];
                        P_CSA: n_x = w_fm;
                        P_C01: begin
                            n_c00 = f_sat32(67'(r_ad) + 67'(r_hv));
                            n_c01 = f_sat32(67'(r_hv) - 67'(w_fm));
                        end
                        P_C10A: n_x = w_fm;
                        P_C10B: n_c10 = f_sat32(-67'(w_half));
                        P_R0A: n_acc = w_fm;
                        P_R0B: begin
                            w_tmp = f_sat32(67'(r_acc) + 67'(w_fm));
                            n_r0  = f_sat32(67'(w_tmp) + 67'(r_tau1));
                        end
                        P_R1A: n_acc = w_fm;
                        P_R1B: n_r1 = f_sat32(67'(r_acc) + 67'(w_fm));
                        P_GRAV: begin
                            w_tmp = f_sat32(67'(r_r1) - 67'(w_fm));
                            n_r1  = f_sat32(67'(w_tmp) + 67'(r_tau2));
                        end
                        P_DETA: n_big = r_prod;
                        P_DETB: begin
                            if (w_det == '0) begin
                                n_sing = 1'b1;
                                n_a0   = '0;
                                n_a1   = '0;
                                n_pc   = P_V1;
                            end else begin
                                n_dmag = w_det[65] ? 66'(-w_det) : 66'(w_det);
                                n_dneg = w_det[65];
                            end
                        end
                        P_N0A, P_N1A: n_big = r_prod;
                        P_N0B, P_N1B: begin
                            n_dq    = w_dabs;
                            n_rem   = '0;
                            n_qneg  = r_dneg ^ w_diff[65];
                            n_dcnt  = DIV_STEPS;
                            n_dsel  = (r_pc == P_N1B);
                            n_state = S_DIV;
                        end
                        P_V1: n_v1 = f_clamp(f_sat32(67'(r_v1) + 67'(w_fm)), r_vl);
                        P_V2: n_v2 = f_clamp(f_sat32(67'(r_v2) + 67'(w_fm)), r_vl);
                        P_A1: n_aa = f_sat32(67'(r_aa) + 67'(w_fm));
                        P_A2: begin
                            n_pa    = f_sat32(67'(r_pa) + 67'(w_fm));
                            n_state = S_DONE;
                        end
                        default: n_pc = P_PHASE;
                    endcase
                end
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    n_rem  = w_ge ? (w_trial - r_dmag) : w_trial;
                    n_dq   = {r_dq[64:0], w_ge};
                    n_dcnt = r_dcnt - 7'd1;
                end else begin
                    if (r_dsel) begin
                        n_a1 = w_q32;
                    end else begin
                        n_a0 = w_q32;
                    end
                    n_state = S_CALC;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= P_PHASE;
            r_wb        <= 1'b0;
            r_sidx      <= SIN_S;
            r_dsel      <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_aa        <= '0;
            r_pa        <= '0;
            r_v1        <= '0;
            r_v2        <= '0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_wb        <= n_wb;
            r_sidx      <= n_sidx;
            r_dsel      <= n_dsel;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
            r_aa        <= n_aa;
            r_pa        <= n_pa;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= 16'd66;
            r_vl <= 31'd1310720;
            r_bi <= 31'd65536;
            r_pi <= 31'd65536;
            r_cg <= '0;
            r_gg <= '0;
            r_ad <= '0;
            r_pd <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_STEP:    r_ts <= i_cfg_data[15:0];
                CFG_VEL_LIMIT:    r_vl <= i_cfg_data[30:0];
                CFG_BASE_INERTIA: r_bi <= i_cfg_data[30:0];
                CFG_PEND_INERTIA: r_pi <= i_cfg_data[30:0];
                CFG_COUPLING:     r_cg <= i_cfg_data;
                CFG_GRAVITY:      r_gg <= i_cfg_data;
                CFG_ARM_DAMP:     r_ad <= i_cfg_data;
                CFG_PEND_DAMP:    r_pd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_tau1 <= n_tau1;  r_tau2 <= n_tau2;  r_sph <= n_sph;  r_u2 <= n_u2;
        r_t <= n_t;  r_s <= n_s;  r_c <= n_c;  r_s2 <= n_s2;  r_x <= n_x;
        r_hv <= n_hv;  r_m00 <= n_m00;  r_m01 <= n_m01;  r_c00 <= n_c00;
        r_c01 <= n_c01;  r_c10 <= n_c10;  r_acc <= n_acc;  r_r0 <= n_r0;
        r_r1 <= n_r1;  r_a0 <= n_a0;  r_a1 <= n_a1;  r_big <= n_big;
        r_dmag <= n_dmag;  r_dq <= n_dq;  r_rem <= n_rem;  r_qneg <= n_qneg;
        r_sing <= n_sing;  r_dneg <= n_dneg;
        if (w_load_out) begin
            r_o_aa   <= r_aa;
            r_o_av   <= r_v1;
            r_o_pa   <= r_pa;
            r_o_pv   <= r_v2;
            r_o_sing <= r_sing;
        end
    end

endmodule

@@ hdl/rps_checker.sv @@
// port-level checks for the pendulum step block, bound to the top level
`timescale 1ns / 1ps
module rps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic signed [31:0]            i_motor_torque,
    input logic signed [31:0]            i_disturbance_torque,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [31:0]            o_arm_angle,
    input logic signed [31:0]            o_arm_velocity,
    input logic signed [31:0]            o_pendulum_angle,
    input logic signed [31:0]            o_pendulum_velocity,
    input logic                          o_singular,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [rps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [31:0]                   i_cfg_data
);
    import rps_pkg::*;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_arm_angle)
            && $stable(o_pendulum_velocity) && $stable(o_singular))
        else $error("output word changed while stalled");

    // one word in computation: no second accept right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // a result cannot appear right after accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared without computation");

    // a new result only comes together with a free input side
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while block still busy");

endmodule

bind rotary_pendulum_sim_step_top rps_checker u_rps_checker (.*);

@@ bench/rotary_pendulum_sim_step_checker.sv @@
// checker for the pendulum step block: predicts each result word and compares
`timescale 1ns / 1ps
module rotary_pendulum_sim_step_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [31:0]            i_motor_torque,
    input  logic signed [31:0]            i_disturbance_torque,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [31:0]            i_arm_angle,
    input  logic signed [31:0]            i_arm_velocity,
    input  logic signed [31:0]            i_pendulum_angle,
    input  logic signed [31:0]            i_pendulum_velocity,
    input  logic                          i_singular,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [rps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import rps_pkg::*;

    typedef struct packed {
        logic signed [31:0] arm_ang;
        logic signed [31:0] arm_vel;
        logic signed [31:0] pend_ang;
        logic signed [31:0] pend_vel;
        logic               sing;
    } t_pend_state;

    localparam longint ONE_F = 64'sd1 << FRAC_BITS_DEF;

    t_pend_state state_q[$];

    longint dt, vlim, j0, j2, kc, kg, b1, b2;
    longint th1, th2, w1, w2;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clip32((a * b) / ONE_F);
    endfunction

    function automatic longint to_phase(input longint ang);
        longint p;
        p = ang * 64'sd683565276;
        return (p >>> FRAC_BITS_DEF) & 64'hFFFFFFFF;
    endfunction

    function automatic longint sine_of(input longint ph);
        longint quad, u, u2, t;
        quad = (ph >> 30) & 3;
        u = ph & 64'h3FFFFFFF;
        if (quad[0]) u = (64'sd1 << 30) - u;
        u2 = (u * u) / (64'sd1 << 30);
        t = 64'sd172273;
        t = 64'sd5026995 - (u2 * t) / (64'sd1 << 30);
        t = 64'sd85569306 - (u2 * t) / (64'sd1 << 30);
        t = 64'sd693598670 - (u2 * t) / (64'sd1 << 30);
        t = 64'sd1686629713 - (u2 * t) / (64'sd1 << 30);
        t = (u * t) / (64'sd1 << 30);
        t = t / (64'sd1 << (30 - FRAC_BITS_DEF));
        return quad[1] ? -t : t;
    endfunction

    // one euler step of the pendulum, also updates the tracked state
    function automatic t_pend_state advance_pendulum(input longint tau1, input longint tau2);
        t_pend_state r;
        longint ph, s, c, s2, m00, m01, m11, hv, c00, c01, c10, r0, r1, det;
        longint n0, n1, a0, a1;
        ph = to_phase(th2);
        s  = sine_of(ph);
        c  = sine_of((ph + 64'h40000000) & 64'hFFFFFFFF);
        s2 = sine_of((ph * 2) & 64'hFFFFFFFF);
        m00 = clip32(j0 + qmul(j2, qmul(s, s)));
        m01 = qmul(kc, c);
        m11 = j2;
        hv  = qmul(qmul(w2, j2), s2) / 2;
        c00 = clip32(b1 + hv);
        c01 = clip32(hv - qmul(qmul(kc, s), w2));
        c10 = clip32(-(qmul(qmul(w1, j2), s2) / 2));
        r0 = clip32(qmul(c00, w1) + qmul(c01, w2));
        r0 = clip32(r0 + tau1);
        r1 = clip32(qmul(c10, w1) + qmul(b2, w2));
        r1 = clip32(r1 - qmul(kg, s));
        r1 = clip32(r1 + tau2);
        det = (m00 * m11 - m01 * m01) / ONE_F;
        a0 = 0;
        a1 = 0;
        r.sing = (det == 0);
        if (det != 0) begin
            n0 = m11 * r0 - m01 * r1;
            n1 = m00 * r1 - m01 * r0;
            a0 = clip32(n0 / det);
            a1 = clip32(n1 / det);
        end
        w1 = clip32(w1 + qmul(a0, dt));
        w2 = clip32(w2 + qmul(a1, dt));
        if (w1 > vlim) w1 = vlim;
        if (w1 < -vlim) w1 = -vlim;
        if (w2 > vlim) w2 = vlim;
        if (w2 < -vlim) w2 = -vlim;
        th1 = clip32(th1 + qmul(w1, dt));
        th2 = clip32(th2 + qmul(w2, dt));
        r.arm_ang  = th1[31:0];
        r.arm_vel  = w1[31:0];
        r.pend_ang = th2[31:0];
        r.pend_vel = w2[31:0];
        return r;
    endfunction

    assign o_pending = state_q.size();

    always @(posedge i_clk) begin
        t_pend_state want;
        if (!i_rst_n) begin
            dt = 66; vlim = 1310720; j0 = 65536; j2 = 65536;
            kc = 0; kg = 0; b1 = 0; b2 = 0;
            th1 = 0; th2 = 0; w1 = 0; w2 = 0;
            state_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIME_STEP:    dt   = i_cfg_data[15:0];
                    CFG_VEL_LIMIT:    vlim = i_cfg_data[30:0];
                    CFG_BASE_INERTIA: j0   = i_cfg_data[30:0];
                    CFG_PEND_INERTIA: j2   = i_cfg_data[30:0];
                    CFG_COUPLING:     kc   = $signed(i_cfg_data);
                    CFG_GRAVITY:      kg   = $signed(i_cfg_data);
                    CFG_ARM_DAMP:     b1   = $signed(i_cfg_data);
                    CFG_PEND_DAMP:    b2   = $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                state_q.insert(state_q.size(),
                               advance_pendulum(i_motor_torque, i_disturbance_torque));
            if (i_out_valid && i_out_ready) begin
                if (state_q.size() == 0) begin
                    $display("%0t: unexpected word, actual %h %h %h %h %b", $time,
                             i_arm_angle, i_arm_velocity, i_pendulum_angle,
                             i_pendulum_velocity, i_singular);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = state_q.pop_front();
                    if (want.arm_ang !== i_arm_angle || want.arm_vel !== i_arm_velocity ||
                        want.pend_ang !== i_pendulum_angle ||
                        want.pend_vel !== i_pendulum_velocity || want.sing !== i_singular)
                    begin
                        $display("%0t: expected %h %h %h %h %b, actual %h %h %h %h %b",
                                 $time, want.arm_ang, want.arm_vel, want.pend_ang,
                                 want.pend_vel, want.sing, i_arm_angle, i_arm_velocity,
                                 i_pendulum_angle, i_pendulum_velocity, i_singular);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/rotary_pendulum_sim_step_top_test.sv @@
// stimulus and verdict for the pendulum step block
`timescale 1ns / 1ps
module rotary_pendulum_sim_step_top_test;
    import rps_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] motor = '0;
    logic signed [31:0] disturb = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] arm_ang, arm_vel, pend_ang, pend_vel;
    logic sing;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit done = 1'b0;

    always #2 i_clk = ~i_clk;

    rotary_pendulum_sim_step_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_motor_torque(motor), .i_disturbance_torque(disturb),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_arm_angle(arm_ang), .o_arm_velocity(arm_vel),
        .o_pendulum_angle(pend_ang), .o_pendulum_velocity(pend_vel),
        .o_singular(sing),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    rotary_pendulum_sim_step_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_motor_torque(motor), .i_disturbance_torque(disturb),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_arm_angle(arm_ang), .i_arm_velocity(arm_vel),
        .i_pendulum_angle(pend_ang), .i_pendulum_velocity(pend_vel),
        .i_singular(sing),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off) begin
            out_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b0;
                1: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !done) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_tick(input logic [31:0] t1, input logic [31:0] t2);
        in_valid <= 1'b1;
        motor    <= t1;
        disturb  <= t2;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_torque();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    task automatic random_settings(input bit extreme);
        write_reg(CFG_TIME_STEP, extreme ? $urandom_range(0, 1) * 32'hffff + 1 :
                                           $urandom_range(1, 3000));
        write_reg(CFG_VEL_LIMIT, extreme ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h0) :
                                           $urandom_range(0, 2000000));
        write_reg(CFG_BASE_INERTIA, extreme ? $urandom & 32'h7fffffff :
                                              $urandom_range(0, 200000));
        write_reg(CFG_PEND_INERTIA, extreme ? $urandom & 32'h7fffffff :
                                              $urandom_range(0, 200000));
        write_reg(CFG_COUPLING, extreme ? $urandom : $signed($urandom_range(0, 200000)) - 100000);
        write_reg(CFG_GRAVITY, extreme ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000);
        write_reg(CFG_ARM_DAMP, extreme ? $urandom : $signed($urandom_range(0, 40000)) - 20000);
        write_reg(CFG_PEND_DAMP, extreme ? $urandom : $signed($urandom_range(0, 40000)) - 20000);
    endtask

    initial begin
        int phase_items;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, torque extremes, singular matrix, then extreme settings
        send_tick(32'h7fffffff, 32'h80000000);
        send_tick(32'h80000000, 32'h7fffffff);
        send_tick(32'h0, 32'h0);
        send_tick(32'hffffffff, 32'h1);
        drain_results();
        write_reg(CFG_BASE_INERTIA, 32'h0);
        write_reg(CFG_PEND_INERTIA, 32'h0);
        send_tick(32'h10000, 32'h10000);
        send_tick(32'h80000000, 32'h7fffffff);
        drain_results();
        write_reg(CFG_BASE_INERTIA, 32'h10000);
        write_reg(CFG_PEND_INERTIA, 32'h8000);
        write_reg(CFG_COUPLING, 32'h7fffffff);
        write_reg(CFG_GRAVITY, 32'h80000000);
        write_reg(CFG_ARM_DAMP, 32'h7fffffff);
        write_reg(CFG_PEND_DAMP, 32'h80000000);
        write_reg(CFG_VEL_LIMIT, 32'h7fffffff);
        write_reg(CFG_TIME_STEP, 32'hffff);
        repeat (6) send_tick(32'h7fffffff, 32'h7fffffff);
        drain_results();
        write_reg(CFG_VEL_LIMIT, 32'h0);
        write_reg(CFG_TIME_STEP, 32'h1);
        send_tick(32'h7fffffff, 32'h80000000);
        send_tick(32'h12345678, 32'hedcba987);
        drain_results();
        // unused index is ignored
        write_reg(8'hff, 32'hdeadbeef);

        // long receiver hold-off so the block backs up
        hold_off <= 1'b1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (3) send_tick(pick_torque(), pick_torque());
        drain_results();

        for (int ph = 0; ph < 16; ph++) begin
            random_settings(ph % 4 == 3);
            phase_items = 100;
            while (phase_items > 0) begin
                send_tick(pick_torque(), pick_torque());
                phase_items--;
                if ($urandom_range(0, 3) == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 400)) @(posedge i_clk);
                end
            end
            drain_results();
        end

        done = 1'b1;
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ rotary_pendulum_sim_step_top.f @@
hdl/rps_pkg.sv
hdl/rotary_pendulum_sim_step_top.sv
hdl/rps_checker.sv
bench/rotary_pendulum_sim_step_checker.sv
bench/rotary_pendulum_sim_step_top_test.sv
